@@ src/a2pt_pkg.sv @@
// Shared types, constants and table functions for the 2-D affine point transform.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package a2pt_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // Reduced angle in 1/64 degree; CORDIC angle adds 16 fraction bits.
  localparam int ANG_W    = 16;
  localparam int ANG_FRAC = 16;
  localparam int VEC_W    = 32;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 16'sd23040;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd5760;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [1:0] {
    ACT_TRANSLATE,
    ACT_SCALE,
    ACT_ROT_CW,
    ACT_ROT_ACW
  } action_e;

  // atan(2^-i) in degrees with 22 fraction bits
  function automatic logic signed [VEC_W-1:0] atan_val(input int idx);
    logic signed [VEC_W-1:0] val;
    unique case (idx)
      0:       val = 32'sd188743680;
      1:       val = 32'sd111421900;
      2:       val = 32'sd58872272;
      3:       val = 32'sd29884485;
      4:       val = 32'sd15000234;
      5:       val = 32'sd7507429;
      6:       val = 32'sd3754631;
      7:       val = 32'sd1877430;
      8:       val = 32'sd938729;
      9:       val = 32'sd469366;
      10:      val = 32'sd234683;
      11:      val = 32'sd117342;
      12:      val = 32'sd58671;
      13:      val = 32'sd29335;
      14:      val = 32'sd14668;
      15:      val = 32'sd7334;
      16:      val = 32'sd3667;
      17:      val = 32'sd1833;
      18:      val = 32'sd917;
      19:      val = 32'sd458;
      20:      val = 32'sd229;
      21:      val = 32'sd115;
      22:      val = 32'sd57;
      23:      val = 32'sd29;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Number of restoring steps that bring |angle| below a full turn
  function automatic int red_steps(input int coord_bits);
    longint lim;
    int     n;
    lim = longint'(1) << (coord_bits - 1);
    n   = 0;
    while ((longint'(FULL_TURN) << n) <= lim) begin
      n++;
    end
    return n;
  endfunction

endpackage

@@ src/a2pt_red_cell.sv @@
// One restoring step of the full-turn angle reduction, with its pipeline register.
// Depends on a2pt_pkg.
`timescale 1ns / 1ps

module a2pt_red_cell #(
  parameter int COORD_BITS = a2pt_pkg::COORD_BITS_DEF,
  parameter int ITEM_W     = 2 + 4 * a2pt_pkg::COORD_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [ITEM_W-1:0]     item_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic                  neg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [ITEM_W-1:0]     item_o,
  output logic [COORD_BITS-1:0] mag_o,
  output logic                  neg_o
);
  import a2pt_pkg::*;

  localparam logic [COORD_BITS:0] STEP = (COORD_BITS + 1)'(longint'(FULL_TURN) << SHIFT);

  logic                  vld_q;
  logic [ITEM_W-1:0]     item_q;
  logic [COORD_BITS-1:0] mag_d, mag_q;
  logic                  neg_q;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    mag_d = mag_i;
    if ({1'b0, mag_i} >= STEP) begin
      mag_d = mag_i - STEP[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
      mag_q  <= mag_d;
      neg_q  <= neg_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

@@ src/a2pt_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// Depends on a2pt_pkg for the arctangent table and vector widths.
`timescale 1ns / 1ps

module a2pt_cordic_cell #(
  parameter int ITEM_W = 2 + 4 * a2pt_pkg::COORD_BITS_DEF,
  parameter int STAGE  = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [ITEM_W-1:0]                      item_i,
  input  logic signed [a2pt_pkg::VEC_W-1:0]      cx_i,
  input  logic signed [a2pt_pkg::VEC_W-1:0]      cy_i,
  input  logic signed [a2pt_pkg::VEC_W-1:0]      z_i,
  input  logic                                   neg_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [ITEM_W-1:0]                      item_o,
  output logic signed [a2pt_pkg::VEC_W-1:0]      cx_o,
  output logic signed [a2pt_pkg::VEC_W-1:0]      cy_o,
  output logic signed [a2pt_pkg::VEC_W-1:0]      z_o,
  output logic                                   neg_o
);
  import a2pt_pkg::*;

  localparam logic signed [VEC_W-1:0] ATAN_I = atan_val(STAGE);

  logic                    vld_q;
  logic [ITEM_W-1:0]       item_q;
  logic signed [VEC_W-1:0] dx, dy;
  logic signed [VEC_W-1:0] cx_d, cy_d, z_d;
  logic signed [VEC_W-1:0] cx_q, cy_q, z_q;
  logic                    neg_q;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    dx = cy_i >>> STAGE;
    dy = cx_i >>> STAGE;
    if (z_i >= 0) begin
      cx_d = cx_i - dx;
      cy_d = cy_i + dy;
      z_d  = z_i - ATAN_I;
    end else begin
      cx_d = cx_i + dx;
      cy_d = cy_i - dy;
      z_d  = z_i + ATAN_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      z_q    <= z_d;
      neg_q  <= neg_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign z_o     = z_q;
  assign neg_o   = neg_q;

endmodule

@@ src/a2pt_out_stage.sv @@
// Output end: sign fold of sine and cosine, products, rounding and saturation.
// Three register stages; depends on a2pt_pkg for the action codes.
`timescale 1ns / 1ps

module a2pt_out_stage #(
  parameter int COORD_BITS = a2pt_pkg::COORD_BITS_DEF,
  parameter int ITEM_W     = 2 + 4 * a2pt_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [ITEM_W-1:0]                 item_i,
  input  logic signed [a2pt_pkg::VEC_W-1:0] cx_i,
  input  logic signed [a2pt_pkg::VEC_W-1:0] cy_i,
  input  logic                              neg_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [COORD_BITS-1:0]      x_out_o,
  output logic signed [COORD_BITS-1:0]      y_out_o,
  output logic                              saturated_o
);
  import a2pt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = CB + VEC_W;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] RND8  = SW'(128);
  localparam logic signed [SW-1:0] RND30 = SW'(1 << 29);
  localparam logic signed [SW-1:0] HI    = $signed({{(SW - CB + 1){1'b0}}, {(CB - 1){1'b1}}});
  localparam logic signed [SW-1:0] LO    = ~HI;
  localparam logic signed [CB-1:0] OUT_HI = $signed({1'b0, {(CB - 1){1'b1}}});
  localparam logic signed [CB-1:0] OUT_LO = $signed({1'b1, {(CB - 1){1'b0}}});

  // stage 1: fold sign, pick multiplier operands
  logic                    v1_q, rdy1;
  logic [ITEM_W-1:0]       item1_q;
  logic signed [VEC_W-1:0] k0_d, k1_d, ks_d, k0_q, k1_q, ks_q;
  action_e                 act0;
  logic signed [CB-1:0]    pa0, pb0;
  logic signed [VEC_W-1:0] c0, s0;
  logic                    rot0;

  // stage 2: products
  logic                    v2_q, rdy2;
  logic [ITEM_W-1:0]       item2_q;
  logic signed [CB-1:0]    x1, y1;
  logic signed [PW-1:0]    m0_q, m1_q, m2_q, m3_q;

  // stage 3: sum, round, clamp
  logic                    v3_q, rdy3;
  action_e                 act2;
  logic signed [CB-1:0]    x2, y2, pa2, pb2;
  logic signed [SW-1:0]    vx, vy;
  logic                    sx, sy;
  logic signed [CB-1:0]    xo_d, yo_d, xo_q, yo_q;
  logic                    sat_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    act0 = action_e'(item_i[ITEM_W-1 -: 2]);
    pa0  = item_i[2*CB-1 -: CB];
    pb0  = item_i[CB-1:0];
    c0   = neg_i ? -cx_i : cx_i;
    s0   = neg_i ? -cy_i : cy_i;
    rot0 = (act0 == ACT_ROT_CW) || (act0 == ACT_ROT_ACW);
    k0_d = rot0 ? c0 : VEC_W'(pa0);
    k1_d = rot0 ? c0 : VEC_W'(pb0);
    ks_d = s0;
  end

  assign x1 = item1_q[4*CB-1 -: CB];
  assign y1 = item1_q[3*CB-1 -: CB];

  always_comb begin
    act2 = action_e'(item2_q[ITEM_W-1 -: 2]);
    x2   = item2_q[4*CB-1 -: CB];
    y2   = item2_q[3*CB-1 -: CB];
    pa2  = item2_q[2*CB-1 -: CB];
    pb2  = item2_q[CB-1:0];
    vx   = SW'(x2) + SW'(pa2);
    vy   = SW'(y2) + SW'(pb2);
    unique case (act2)
      ACT_TRANSLATE: begin
        vx = SW'(x2) + SW'(pa2);
        vy = SW'(y2) + SW'(pb2);
      end
      ACT_SCALE: begin
        vx = (SW'(m0_q) + RND8) >>> 8;
        vy = (SW'(m1_q) + RND8) >>> 8;
      end
      ACT_ROT_CW: begin
        vx = (SW'(m0_q) + SW'(m3_q) + RND30) >>> 30;
        vy = (SW'(m1_q) - SW'(m2_q) + RND30) >>> 30;
      end
      ACT_ROT_ACW: begin
        vx = (SW'(m0_q) - SW'(m3_q) + RND30) >>> 30;
        vy = (SW'(m2_q) + SW'(m1_q) + RND30) >>> 30;
      end
      default: begin
        vx = SW'(x2);
        vy = SW'(y2);
      end
    endcase
    sx   = (vx > HI) || (vx < LO);
    sy   = (vy > HI) || (vy < LO);
    xo_d = (vx > HI) ? OUT_HI : (vx < LO) ? OUT_LO : vx[CB-1:0];
    yo_d = (vy > HI) ? OUT_HI : (vy < LO) ? OUT_LO : vy[CB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      item1_q <= item_i;
      k0_q    <= k0_d;
      k1_q    <= k1_d;
      ks_q    <= ks_d;
    end
    if (rdy2 && v1_q) begin
      item2_q <= item1_q;
      m0_q    <= x1 * k0_q;
      m1_q    <= y1 * k1_q;
      m2_q    <= x1 * ks_q;
      m3_q    <= y1 * ks_q;
    end
    if (rdy3 && v2_q) begin
      xo_q  <= xo_d;
      yo_q  <= yo_d;
      sat_q <= sx || sy;
    end
  end

  assign valid_o     = v3_q;
  assign x_out_o     = xo_q;
  assign y_out_o     = yo_q;
  assign saturated_o = sat_q;

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && sat_q) |-> (xo_q == OUT_HI || xo_q == OUT_LO || yo_q == OUT_HI || yo_q == OUT_LO))
    else $error("saturation flagged with no coordinate at a rail");

endmodule

@@ src/affine_2d_point_transform.sv @@
// 2-D affine point transform: translate, scale and rotate one vertex per request.
// Pipeline: entry register, reduction cells, fold register, CORDIC cells, output stage;
// throughput one request per cycle while out_ready_i does not stall the output.
// Reset clears only the stage valid flags; no clearing pass. Depends on a2pt_pkg.
`timescale 1ns / 1ps

module affine_2d_point_transform #(
  parameter int COORD_BITS    = a2pt_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = a2pt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] x_in_i,
  input  logic signed [COORD_BITS-1:0] y_in_i,
  input  logic signed [COORD_BITS-1:0] param_a_i,
  input  logic signed [COORD_BITS-1:0] param_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] x_out_o,
  output logic signed [COORD_BITS-1:0] y_out_o,
  output logic                         saturated_o
);
  import a2pt_pkg::*;

  localparam int ITEM_W = 2 + 4 * COORD_BITS;
  localparam int NRED   = red_steps(COORD_BITS);
  localparam int NST    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam logic signed [VEC_W-1:0] ZLIM = $signed({QUARTER_TURN, {ANG_FRAC{1'b0}}});

  // entry stage: magnitude and sign of the angle
  logic                  ent_vld_q;
  logic [ITEM_W-1:0]     ent_item_q;
  logic [COORD_BITS-1:0] ent_mag_d, ent_mag_q;
  logic                  ent_neg_q;

  logic                  red_vld  [NRED+1];
  logic                  red_rdy  [NRED+1];
  logic [ITEM_W-1:0]     red_item [NRED+1];
  logic [COORD_BITS-1:0] red_mag  [NRED+1];
  logic                  red_neg  [NRED+1];

  // fold stage: wrap to half turn, fold beyond quarter turn
  logic                    fold_vld_q, fold_rdy;
  logic [ITEM_W-1:0]       fold_item_q;
  logic signed [ANG_W-1:0] r0, r1, r2;
  logic                    fold_neg_d, fold_neg_q;
  logic signed [VEC_W-1:0] fold_z_d, fold_z_q;

  logic                    cor_vld  [NST+1];
  logic                    cor_rdy  [NST+1];
  logic [ITEM_W-1:0]       cor_item [NST+1];
  logic signed [VEC_W-1:0] cor_x    [NST+1];
  logic signed [VEC_W-1:0] cor_y    [NST+1];
  logic signed [VEC_W-1:0] cor_z    [NST+1];
  logic                    cor_neg  [NST+1];

  assign in_ready_o = !ent_vld_q || red_rdy[0];
  assign ent_mag_d  = param_a_i[COORD_BITS-1] ? COORD_BITS'(-param_a_i)
                                              : COORD_BITS'(param_a_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      ent_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ent_item_q <= {action_i, x_in_i, y_in_i, param_a_i, param_b_i};
      ent_mag_q  <= ent_mag_d;
      ent_neg_q  <= param_a_i[COORD_BITS-1];
    end
  end

  assign red_vld[0]  = ent_vld_q;
  assign red_item[0] = ent_item_q;
  assign red_mag[0]  = ent_mag_q;
  assign red_neg[0]  = ent_neg_q;

  for (genvar g = 0; g < NRED; g++) begin : g_red
    a2pt_red_cell #(
      .COORD_BITS(COORD_BITS),
      .ITEM_W    (ITEM_W),
      .SHIFT     (NRED - 1 - g)
    ) u_red (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(red_vld[g]),
      .ready_o(red_rdy[g]),
      .item_i (red_item[g]),
      .mag_i  (red_mag[g]),
      .neg_i  (red_neg[g]),
      .valid_o(red_vld[g+1]),
      .ready_i(red_rdy[g+1]),
      .item_o (red_item[g+1]),
      .mag_o  (red_mag[g+1]),
      .neg_o  (red_neg[g+1])
    );
  end

  assign fold_rdy      = !fold_vld_q || cor_rdy[0];
  assign red_rdy[NRED] = fold_rdy;

  always_comb begin
    r0 = red_neg[NRED] ? -ANG_W'(red_mag[NRED]) : ANG_W'(red_mag[NRED]);
    r1 = r0;
    if (r0 > HALF_TURN) begin
      r1 = r0 - FULL_TURN;
    end else if (r0 < -HALF_TURN) begin
      r1 = r0 + FULL_TURN;
    end
    r2         = r1;
    fold_neg_d = 1'b0;
    if (r1 > QUARTER_TURN) begin
      r2         = r1 - HALF_TURN;
      fold_neg_d = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2         = r1 + HALF_TURN;
      fold_neg_d = 1'b1;
    end
    fold_z_d = $signed({r2, {ANG_FRAC{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (fold_rdy) begin
      fold_vld_q <= red_vld[NRED];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_rdy && red_vld[NRED]) begin
      fold_item_q <= red_item[NRED];
      fold_z_q    <= fold_z_d;
      fold_neg_q  <= fold_neg_d;
    end
  end

  assign cor_vld[0]  = fold_vld_q;
  assign cor_item[0] = fold_item_q;
  assign cor_x[0]    = CORDIC_GAIN;
  assign cor_y[0]    = '0;
  assign cor_z[0]    = fold_z_q;
  assign cor_neg[0]  = fold_neg_q;

  for (genvar g = 0; g < NST; g++) begin : g_cor
    a2pt_cordic_cell #(
      .ITEM_W(ITEM_W),
      .STAGE (g)
    ) u_cor (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cor_vld[g]),
      .ready_o(cor_rdy[g]),
      .item_i (cor_item[g]),
      .cx_i   (cor_x[g]),
      .cy_i   (cor_y[g]),
      .z_i    (cor_z[g]),
      .neg_i  (cor_neg[g]),
      .valid_o(cor_vld[g+1]),
      .ready_i(cor_rdy[g+1]),
      .item_o (cor_item[g+1]),
      .cx_o   (cor_x[g+1]),
      .cy_o   (cor_y[g+1]),
      .z_o    (cor_z[g+1]),
      .neg_o  (cor_neg[g+1])
    );
  end

  a2pt_out_stage #(
    .COORD_BITS(COORD_BITS),
    .ITEM_W    (ITEM_W)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cor_vld[NST]),
    .ready_o    (cor_rdy[NST]),
    .item_i     (cor_item[NST]),
    .cx_i       (cor_x[NST]),
    .cy_i       (cor_y[NST]),
    .neg_i      (cor_neg[NST]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .saturated_o(saturated_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output side is free");

  a_reduced_below_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_vld[NRED] |-> (32'(red_mag[NRED]) < 32'(FULL_TURN)))
    else $error("angle magnitude not reduced below a full turn");

  a_fold_in_quarter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_vld_q |-> ((fold_z_q <= ZLIM) && (fold_z_q >= -ZLIM)))
    else $error("folded CORDIC angle outside a quarter turn");

endmodule

@@ bench/vertex_transform_checker.sv @@
// Checker for the 2-D affine point transform: watches the request and result channels,
// predicts each transformed vertex and compares it with what the block returns.
// Depends on a2pt_pkg for the action codes and angle constants.
`timescale 1ns / 1ps

module vertex_transform_checker #(
  parameter int COORD_BITS    = a2pt_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = a2pt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] x_in_i,
  input  logic signed [COORD_BITS-1:0] y_in_i,
  input  logic signed [COORD_BITS-1:0] param_a_i,
  input  logic signed [COORD_BITS-1:0] param_b_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [COORD_BITS-1:0] x_out_i,
  input  logic signed [COORD_BITS-1:0] y_out_i,
  input  logic                         saturated_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import a2pt_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         sat;
  } vertex_t;

  localparam longint ATAN_DEG22 [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  vertex_t expected_vertices[$];

  // Rotation-mode CORDIC on an angle in 1/64 degree; results are Q2.30.
  function automatic void unit_rotation(input longint ang, output longint cos_q30,
                                        output longint sin_q30);
    longint r, vx, vy, z, dx, dy, full_t, half_t, quarter_t;
    bit     flip;
    int     i;
    full_t    = longint'(FULL_TURN);
    half_t    = longint'(HALF_TURN);
    quarter_t = longint'(QUARTER_TURN);
    flip = 1'b0;
    r = ang % full_t;
    if (r > half_t) r -= full_t;
    if (r < -half_t) r += full_t;
    if (r > quarter_t) begin
      r -= half_t;
      flip = 1'b1;
    end else if (r < -quarter_t) begin
      r += half_t;
      flip = 1'b1;
    end
    z  = r * 65536;
    vx = longint'(CORDIC_GAIN);
    vy = 0;
    for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - ATAN_DEG22[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + ATAN_DEG22[i];
      end
    end
    cos_q30 = flip ? -vx : vx;
    sin_q30 = flip ? -vy : vy;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] saturate(input longint v, inout bit flag);
    longint hi, lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      v = hi;
    end else if (v < lo) begin
      flag = 1'b1;
      v = lo;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic vertex_t transform_vertex(input action_e act,
      input logic signed [COORD_BITS-1:0] x, y, pa, pb);
    longint  xs, ys, as, bs, rx, ry, c, s;
    bit      flag;
    vertex_t res;
    xs = longint'(x);
    ys = longint'(y);
    as = longint'(pa);
    bs = longint'(pb);
    flag = 1'b0;
    case (act)
      ACT_TRANSLATE: begin
        rx = xs + as;
        ry = ys + bs;
      end
      ACT_SCALE: begin
        rx = (xs * as + 128) >>> 8;
        ry = (ys * bs + 128) >>> 8;
      end
      default: begin
        unit_rotation(as, c, s);
        if (act == ACT_ROT_CW) begin
          rx = xs * c + ys * s;
          ry = ys * c - xs * s;
        end else begin
          rx = xs * c - ys * s;
          ry = xs * s + ys * c;
        end
        rx = (rx + (longint'(1) <<< 29)) >>> 30;
        ry = (ry + (longint'(1) <<< 29)) >>> 30;
      end
    endcase
    res.x   = saturate(rx, flag);
    res.y   = saturate(ry, flag);
    res.sat = flag;
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                   x_out_i, y_out_i, saturated_i);
        end else begin
          want = expected_vertices.pop_front();
          if (x_out_i !== want.x) begin
            fail_count_o++;
            $display("%0t: x_out expected %0d actual %0d", $time, want.x, x_out_i);
          end
          if (y_out_i !== want.y) begin
            fail_count_o++;
            $display("%0t: y_out expected %0d actual %0d", $time, want.y, y_out_i);
          end
          if (saturated_i !== want.sat) begin
            fail_count_o++;
            $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                     saturated_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_vertices.push_back(transform_vertex(action_e'(action_i), x_in_i, y_in_i,
                                                     param_a_i, param_b_i));
      pending_o = expected_vertices.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the affine point transform bench: clock, reset, request stimulus and verdict.
// Depends on a2pt_pkg, affine_2d_point_transform and vertex_transform_checker.
`timescale 1ns / 1ps

module tb_top;
  import a2pt_pkg::*;

  localparam int COORD_BITS  = a2pt_pkg::COORD_BITS_DEF;
  localparam int RANDOM_REQS = 1250;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready;
  action_e                      action;
  logic signed [COORD_BITS-1:0] x_in, y_in, param_a, param_b;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [COORD_BITS-1:0] x_out, y_out;
  logic                         saturated;
  int                           fail_count, pending, accepted_cnt, quiet_cycles;
  logic                         burst_mode;

  always #10 clk_i = ~clk_i;

  affine_2d_point_transform dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .x_in_i      (x_in),
    .y_in_i      (y_in),
    .param_a_i   (param_a),
    .param_b_i   (param_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .x_out_o     (x_out),
    .y_out_o     (y_out),
    .saturated_o (saturated)
  );

  vertex_transform_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .x_in_i       (x_in),
    .y_in_i       (y_in),
    .param_a_i    (param_a),
    .param_b_i    (param_b),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .x_out_i      (x_out),
    .y_out_i      (y_out),
    .saturated_i  (saturated),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  assign burst_mode = (accepted_cnt >= 400) && (accepted_cnt < 600);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_cnt <= 0;
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) accepted_cnt <= accepted_cnt + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("affine_2d_point_transform verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the pipeline up.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && accepted_cnt >= 800) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= burst_mode || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  task automatic send_request(input action_e act, input logic signed [COORD_BITS-1:0] xv,
                              input logic signed [COORD_BITS-1:0] yv,
                              input logic signed [COORD_BITS-1:0] av,
                              input logic signed [COORD_BITS-1:0] bv);
    while (!burst_mode && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    x_in     <= xv;
    y_in     <= yv;
    param_a  <= av;
    param_b  <= bv;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return COORD_BITS'($urandom);
    if (sel < 80) return COORD_BITS'($urandom_range(0, 600) - 300);
    if (sel < 90) return COORD_BITS'(32767 - $urandom_range(0, 3));
    return COORD_BITS'(-32768 + $urandom_range(0, 3));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_scale();
    if ($urandom_range(0, 1)) return COORD_BITS'($urandom);
    return COORD_BITS'($urandom_range(0, 2048) - 1024);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return COORD_BITS'($urandom);
    if (sel < 70) begin
      return COORD_BITS'(5760 * ($urandom_range(0, 10) - 5) + $urandom_range(0, 8) - 4);
    end
    return COORD_BITS'($urandom_range(0, 46080) - 23040);
  endfunction

  initial begin
    action_e act;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    action   <= ACT_TRANSLATE;
    x_in     <= '0;
    y_in     <= '0;
    param_a  <= '0;
    param_b  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_TRANSLATE, 100, -200, 5, 7);
    send_request(ACT_TRANSLATE, 32767, 0, 1, 0);
    send_request(ACT_TRANSLATE, 0, -32768, 0, -1);
    send_request(ACT_TRANSLATE, -32768, 32767, -32768, 32767);
    send_request(ACT_SCALE, 300, -300, 256, 256);
    send_request(ACT_SCALE, 1, -1, 128, 128);
    send_request(ACT_SCALE, -32768, -32768, -32768, 32767);
    send_request(ACT_SCALE, 32767, 1000, -256, 0);
    send_request(ACT_ROT_CW, 1000, 0, 0, 12345);
    send_request(ACT_ROT_ACW, 1000, 500, 0, -1);
    send_request(ACT_ROT_CW, 1000, 500, 5760, 0);
    send_request(ACT_ROT_ACW, 1000, 500, 5760, 0);
    send_request(ACT_ROT_CW, -700, 300, 11520, 0);
    send_request(ACT_ROT_ACW, -700, 300, -11520, 0);
    send_request(ACT_ROT_CW, 250, 250, 5761, 0);
    send_request(ACT_ROT_ACW, 250, 250, -5761, 0);
    send_request(ACT_ROT_CW, 400, -400, 15000, 0);
    send_request(ACT_ROT_ACW, 400, -400, -23040, 0);
    send_request(ACT_ROT_CW, 32767, 32767, 2880, 0);
    send_request(ACT_ROT_ACW, -32768, -32768, 2880, 0);
    send_request(ACT_ROT_CW, 1234, -4321, 32767, 0);
    send_request(ACT_ROT_ACW, 1234, -4321, -32768, 0);

    repeat (RANDOM_REQS) begin
      act = action_e'($urandom_range(0, 3));
      case (act)
        ACT_TRANSLATE: send_request(act, pick_coord(), pick_coord(), pick_coord(),
                                    pick_coord());
        ACT_SCALE:     send_request(act, pick_coord(), pick_coord(), pick_scale(),
                                    pick_scale());
        default:       send_request(act, pick_coord(), pick_coord(), pick_angle(),
                                    COORD_BITS'($urandom));
      endcase
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("affine_2d_point_transform verification clean");
    else
      $display("affine_2d_point_transform verification failed");
    $finish;
  end

endmodule
